// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion checked during reset too.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/ffha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and codes of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int OFS_W = 20;
    localparam int REQ_W = 21;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOFIT    = 2'd1;
    localparam logic [1:0] ST_NOTSTART = 2'd2;
    localparam logic [1:0] ST_NULL     = 2'd3;

    typedef struct packed {
        logic [OFS_W-1:0] start;
        logic [OFS_W-1:0] size;
        logic             free;
    } seg_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCN_RD,
        S_SCN_EV,
        S_SHF_RD,
        S_SHF_WR,
        S_INS,
        S_MRG_RD,
        S_MRG_EV,
        S_MRG_END,
        S_RESP
    } fsm_t;

endpackage

// File: rtl/first_fit_heap_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit allocator over an address-ordered segment table in one RAM.
// ----------------------------------------------------------------------------
// One request at a time. The segment table sits in a RAM with one write
// port and one registered read port, so every table entry visited is read,
// then evaluated. An allocate scans entries until the first fit; when a
// split adds a new segment, the entries after the fit are moved up one by
// one and the new segment is inserted after the fit. A free scans for
// the matching block the same way, then runs a merge sweep over the whole
// table. A null free (offset zero) answers without a scan.
// After reset the block writes the initial free segment, then takes requests.
// The result sits in an output register, so a new request can be taken while
// the last answer still waits to be read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module first_fit_heap_allocator_unit
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = 1048576,
    parameter int HEADER_BYTES = 24,
    parameter int MAX_SEGMENTS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    // configuration
    input  logic             split_slack_we,
    input  logic [7:0]       split_slack,
    // request transaction
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             op,
    input  logic [REQ_W-1:0] request_bytes,
    input  logic [OFS_W-1:0] release_offset,
    // result transaction
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OFS_W-1:0] payload_offset,
    output logic [1:0]       status
);

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0]    CNT_MAX = CW'(MAX_SEGMENTS);
    localparam logic [CW-1:0]    CNT_ONE = CW'(1);
    localparam logic [OFS_W-1:0] HDR20   = OFS_W'(HEADER_BYTES);
    localparam logic [REQ_W-1:0] HDR21   = REQ_W'(HEADER_BYTES);
    localparam logic [OFS_W-1:0] INIT_SZ = OFS_W'(HEAP_BYTES - HEADER_BYTES);

    // segment table RAM
    seg_t          mem [MAX_SEGMENTS];
    seg_t          rd_q;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          wr_en;
    seg_t          wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    // control and working registers
    fsm_t             state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;     // segment count
    logic [CW-1:0]    k_reg, k_next;         // scan / merge read index
    logic [CW-1:0]    w_reg, w_next;         // shift or merge write index
    logic             acc_v_reg, acc_v_next;
    seg_t             acc_reg, acc_next;     // merge accumulator
    logic             op_reg, op_next;
    logic [REQ_W-1:0] req_reg, req_next;
    logic [OFS_W-1:0] off_reg, off_next;
    logic [OFS_W-1:0] at_reg, at_next;       // split remainder start
    logic [OFS_W-1:0] rest_reg, rest_next;   // split remainder size
    logic [OFS_W-1:0] res_off_reg, res_off_next;
    logic [1:0]       res_st_reg, res_st_next;
    logic [7:0]       slack_reg;
    logic             out_valid_reg, out_valid_next;
    logic [OFS_W-1:0] payload_offset_reg, payload_offset_next;
    logic [1:0]       status_reg, status_next;

    // evaluate terms on the entry just read
    logic             fit;
    logic             do_split;
    logic             hit;
    logic [REQ_W+1:0] need;
    logic [REQ_W+1:0] size_x;
    logic [REQ_W+1:0] req_hdr;
    logic             last;

    assign size_x  = (REQ_W+2)'(rd_q.size);
    assign req_hdr = (REQ_W+2)'(req_reg) + (REQ_W+2)'(HEADER_BYTES);
    assign need    = req_hdr + (REQ_W+2)'(slack_reg);
    assign fit     = rd_q.free && ({1'b0, rd_q.size} >= req_reg);
    assign do_split = (size_x >= need) && (cnt_reg < CNT_MAX) && (size_x > req_hdr);
    assign hit     = (({1'b0, rd_q.start} + HDR21) == {1'b0, off_reg});
    assign last    = ((k_reg + CNT_ONE) == cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= CNT_ONE;
            acc_v_reg     <= 1'b0;
            slack_reg     <= 8'd8;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            acc_v_reg     <= acc_v_next;
            out_valid_reg <= out_valid_next;
            if (split_slack_we)
            begin
                slack_reg <= split_slack;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg              <= k_next;
        w_reg              <= w_next;
        acc_reg            <= acc_next;
        op_reg             <= op_next;
        req_reg            <= req_next;
        off_reg            <= off_next;
        at_reg             <= at_next;
        rest_reg           <= rest_next;
        res_off_reg        <= res_off_next;
        res_st_reg         <= res_st_next;
        payload_offset_reg <= payload_offset_next;
        status_reg         <= status_next;
    end

    always_comb
    begin
        state_next          = state_reg;
        cnt_next            = cnt_reg;
        k_next              = k_reg;
        w_next              = w_reg;
        acc_v_next          = acc_v_reg;
        acc_next            = acc_reg;
        op_next             = op_reg;
        req_next            = req_reg;
        off_next            = off_reg;
        at_next             = at_reg;
        rest_next           = rest_reg;
        res_off_next        = res_off_reg;
        res_st_next         = res_st_reg;
        out_valid_next      = out_valid_reg;
        payload_offset_next = payload_offset_reg;
        status_next         = status_reg;
        rd_addr             = k_reg[IW-1:0];
        wr_en               = 1'b0;
        wr_addr             = k_reg[IW-1:0];
        wr_data             = rd_q;
        in_ready            = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                // table reset: one free segment over the whole heap
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = '{start: '0, size: INIT_SZ, free: 1'b1};
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next  = op;
                    req_next = request_bytes;
                    off_next = release_offset;
                    k_next   = '0;
                    if (op == OP_FREE && release_offset == '0)
                    begin
                        res_off_next = '0;
                        res_st_next  = ST_NULL;
                        state_next   = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCN_RD;
                    end
                end
            end
            S_SCN_RD:
            begin
                rd_addr    = k_reg[IW-1:0];
                state_next = S_SCN_EV;
            end
            S_SCN_EV:
            begin
                if (op_reg == OP_ALLOC && fit)
                begin
                    wr_en        = 1'b1;
                    wr_addr      = k_reg[IW-1:0];
                    wr_data      = '{start: rd_q.start,
                                     size: do_split ? req_reg[OFS_W-1:0] : rd_q.size,
                                     free: 1'b0};
                    res_off_next = rd_q.start + HDR20;
                    res_st_next  = ST_DONE;
                    rest_next    = rd_q.size - req_reg[OFS_W-1:0] - HDR20;
                    at_next      = rd_q.start + HDR20 + req_reg[OFS_W-1:0];
                    w_next       = cnt_reg;
                    if (!do_split)
                    begin
                        state_next = S_RESP;
                    end
                    else if (last)
                    begin
                        state_next = S_INS;
                    end
                    else
                    begin
                        state_next = S_SHF_RD;
                    end
                end
                else if (op_reg == OP_FREE && hit)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = k_reg[IW-1:0];
                    wr_data    = '{start: rd_q.start, size: rd_q.size, free: 1'b1};
                    k_next     = '0;
                    w_next     = '0;
                    acc_v_next = 1'b0;
                    state_next = S_MRG_RD;
                end
                else if (last)
                begin
                    res_off_next = '0;
                    res_st_next  = (op_reg == OP_ALLOC) ? ST_NOFIT : ST_NOTSTART;
                    state_next   = S_RESP;
                end
                else
                begin
                    k_next     = k_reg + CNT_ONE;
                    state_next = S_SCN_RD;
                end
            end
            S_SHF_RD:
            begin
                // move entry w-1 up to w
                rd_addr    = IW'(w_reg - CNT_ONE);
                state_next = S_SHF_WR;
            end
            S_SHF_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = w_reg[IW-1:0];
                wr_data = rd_q;
                w_next  = w_reg - CNT_ONE;
                if ((w_reg - CNT_ONE) == (k_reg + CNT_ONE))
                begin
                    state_next = S_INS;
                end
                else
                begin
                    state_next = S_SHF_RD;
                end
            end
            S_INS:
            begin
                wr_en      = 1'b1;
                wr_addr    = IW'(k_reg + CNT_ONE);
                wr_data    = '{start: at_reg, size: rest_reg, free: 1'b1};
                cnt_next   = cnt_reg + CNT_ONE;
                state_next = S_RESP;
            end
            S_MRG_RD:
            begin
                rd_addr    = k_reg[IW-1:0];
                state_next = S_MRG_EV;
            end
            S_MRG_EV:
            begin
                // write side never overtakes the read side (w <= k)
                if (acc_v_reg && acc_reg.free && rd_q.free)
                begin
                    acc_next.size = acc_reg.size + HDR20 + rd_q.size;
                end
                else
                begin
                    if (acc_v_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = w_reg[IW-1:0];
                        wr_data = acc_reg;
                        w_next  = w_reg + CNT_ONE;
                    end
                    acc_next   = rd_q;
                    acc_v_next = 1'b1;
                end
                k_next     = k_reg + CNT_ONE;
                state_next = last ? S_MRG_END : S_MRG_RD;
            end
            S_MRG_END:
            begin
                wr_en        = 1'b1;
                wr_addr      = w_reg[IW-1:0];
                wr_data      = acc_reg;
                cnt_next     = w_reg + CNT_ONE;
                res_off_next = '0;
                res_st_next  = ST_DONE;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next      = 1'b1;
                    payload_offset_next = res_off_reg;
                    status_next         = res_st_reg;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign payload_offset = payload_offset_reg;
    assign status         = status_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `ASSERT_CLK(a_cnt_range, clk, rst_n, (cnt_reg != '0) && (cnt_reg <= CNT_MAX), "segment count out of range")
    `ASSERT_CLK(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready, "request taken while busy")
    `ASSERT_CLK(a_fail_no_offset, clk, rst_n, out_valid && (status != ST_DONE) |-> payload_offset == '0, "failed request with offset")

endmodule
